>>> sv/pcmup_pkg.sv
// Shared types, constants and helper functions for the PCM repeat upsampler.
// No dependencies; compiled first.
package pcmup_pkg;

  localparam int MAX_REPEAT = 4;
  localparam int REP_W      = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef logic [15:0] sample_t;
  typedef logic [2:0]  cfg_index_t;
  typedef logic [18:0] cfg_data_t;
  typedef logic [18:0] rate_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_SAMPLE_BITS   = 3'd1,
    REG_SOURCE_RATE   = 3'd2,
    REG_OUT48K        = 3'd3,
    REG_OUT44K        = 3'd4
  } cfg_reg_e;

  localparam rate_t RATE_48000 = 19'd48000;
  localparam rate_t RATE_24000 = 19'd24000;
  localparam rate_t RATE_12000 = 19'd12000;
  localparam rate_t RATE_44100 = 19'd44100;
  localparam rate_t RATE_22050 = 19'd22050;
  localparam rate_t RATE_11025 = 19'd11025;

  localparam logic [5:0] BITS_8  = 6'd8;
  localparam logic [5:0] BITS_16 = 6'd16;
  localparam logic [5:0] BITS_24 = 6'd24;
  localparam logic [5:0] BITS_32 = 6'd32;

  typedef struct packed {
    sample_t          left;
    sample_t          right;
    logic             rate_sel;
    logic             fmt_err;
    logic [REP_W-1:0] last_idx;
  } frame_entry_t;

  // 8-bit samples are unsigned and scaled by 64 into the 16-bit range.
  function automatic sample_t widen_sample(sample_t raw, logic eight);
    if (eight) begin
      return {2'b00, raw[7:0], 6'b000000};
    end
    return raw;
  endfunction

endpackage

>>> sv/pcmup_if.sv
// Handshake channel interfaces for the PCM repeat upsampler.
// Depends on pcmup_pkg.
interface pcmup_in_if;
  logic               valid;
  logic               ready;
  pcmup_pkg::sample_t first_raw;
  pcmup_pkg::sample_t second_raw;

  modport source (output valid, output first_raw, output second_raw, input ready);
  modport sink   (input valid, input first_raw, input second_raw, output ready);
endinterface

interface pcmup_out_if;
  logic               valid;
  logic               ready;
  pcmup_pkg::sample_t left_out;
  pcmup_pkg::sample_t right_out;
  logic               out_rate_sel;
  logic               format_error;
  logic               last_of_run;

  modport source (output valid, output left_out, output right_out, output out_rate_sel,
                  output format_error, output last_of_run, input ready);
  modport sink   (input valid, input left_out, input right_out, input out_rate_sel,
                  input format_error, input last_of_run, output ready);
endinterface

interface pcmup_cfg_if;
  logic                  valid;
  logic                  ready;
  pcmup_pkg::cfg_index_t index;
  pcmup_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/pcmup_front.sv
// Front end: configuration registers, request intake and classification
// into queue entries. Depends on pcmup_pkg and pcmup_if.
module pcmup_front (
  input  logic                    clk,
  input  logic                    rst,
  pcmup_in_if.sink                sample_in,
  pcmup_cfg_if.sink               cfg,
  output pcmup_pkg::frame_entry_t push_entry,
  output logic                    push_valid,
  input  logic                    push_ready
);
  import pcmup_pkg::*;

  logic [7:0] channel_count;
  logic [5:0] sample_bits;
  rate_t      source_rate;
  logic       out48k;
  logic       out44k;

  logic       bits_ok;
  logic       eight;
  logic       mono;
  logic [2:0] reps;
  logic [2:0] reps_sat;
  logic       sel44;
  sample_t    left;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 8'd2;
      sample_bits   <= BITS_16;
      source_rate   <= RATE_48000;
      out48k        <= 1'b1;
      out44k        <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_CHANNEL_COUNT: channel_count <= cfg.data[7:0];
        REG_SAMPLE_BITS:   sample_bits   <= cfg.data[5:0];
        REG_SOURCE_RATE:   source_rate   <= cfg.data;
        REG_OUT48K:        out48k        <= cfg.data[0];
        REG_OUT44K:        out44k        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign bits_ok = (sample_bits == BITS_8) || (sample_bits == BITS_16) ||
                   (sample_bits == BITS_24) || (sample_bits == BITS_32);
  assign eight   = (sample_bits == BITS_8);
  assign mono    = (channel_count <= 8'd1);

  always_comb begin
    reps  = 3'd0;
    sel44 = 1'b0;
    if (out48k && bits_ok) begin
      priority if (source_rate == RATE_48000) begin
        reps = 3'd1;
      end else if (source_rate == RATE_24000) begin
        reps = 3'd2;
      end else if (source_rate == RATE_12000) begin
        reps = 3'd4;
      end else if (out44k && source_rate == RATE_44100) begin
        reps  = 3'd1;
        sel44 = 1'b1;
      end else if (out44k && source_rate == RATE_22050) begin
        reps  = 3'd2;
        sel44 = 1'b1;
      end else if (out44k && source_rate == RATE_11025) begin
        reps  = 3'd4;
        sel44 = 1'b1;
      end else begin
        reps = 3'd0;
      end
    end
  end

  assign reps_sat = (reps > 3'(MAX_REPEAT)) ? 3'(MAX_REPEAT) : reps;
  assign left     = widen_sample(sample_in.first_raw, eight);

  always_comb begin
    if (reps == 3'd0) begin
      push_entry.left     = '0;
      push_entry.right    = '0;
      push_entry.rate_sel = 1'b0;
      push_entry.fmt_err  = 1'b1;
      push_entry.last_idx = '0;
    end else begin
      push_entry.left     = left;
      push_entry.right    = mono ? left : widen_sample(sample_in.second_raw, eight);
      push_entry.rate_sel = sel44;
      push_entry.fmt_err  = 1'b0;
      push_entry.last_idx = REP_W'(reps_sat - 3'd1);
    end
  end

  assign push_valid      = sample_in.valid;
  assign sample_in.ready = push_ready;

endmodule

>>> sv/pcmup_queue.sv
// Small FIFO of classified frame entries between front and back end.
// Depends on pcmup_pkg.
module pcmup_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  pcmup_pkg::frame_entry_t push_entry,
  input  logic                    push_valid,
  output logic                    push_ready,
  output pcmup_pkg::frame_entry_t pop_entry,
  output logic                    pop_valid,
  input  logic                    pop_ready
);
  import pcmup_pkg::*;

  frame_entry_t     entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> sv/pcmup_back.sv
// Back end: output register and repeat counter that replays each entry.
// Depends on pcmup_pkg and pcmup_if.
module pcmup_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pcmup_pkg::frame_entry_t pop_entry,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  pcmup_out_if.source             frame_out
);
  import pcmup_pkg::*;

  frame_entry_t     cur;
  logic             cur_valid;
  logic [REP_W-1:0] cnt;
  logic             take;
  logic             last;
  logic             load;

  assign last      = (cnt == cur.last_idx);
  assign take      = frame_out.valid && frame_out.ready;
  assign pop_ready = !cur_valid || (take && last);
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      cnt       <= '0;
    end else if (take && last) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_entry;
    end
  end

  assign frame_out.valid        = cur_valid;
  assign frame_out.left_out     = cur.left;
  assign frame_out.right_out    = cur.right;
  assign frame_out.out_rate_sel = cur.rate_sel;
  assign frame_out.format_error = cur.fmt_err;
  assign frame_out.last_of_run  = last;

endmodule

>>> sv/pcm_stereo16_upsample_converter_core.sv
// Top level of the PCM repeat upsampler: front end, entry queue, back end.
// Depends on pcmup_pkg, pcmup_if, pcmup_front, pcmup_queue, pcmup_back.
//
// Usage:
//   sample_in : one PCM frame per request (first_raw, second_raw).
//   frame_out : stereo 16-bit frames; each input request yields 1, 2 or 4
//               identical frames, last_of_run marks the final one. An
//               unsupported format yields one frame with format_error set.
//   cfg       : register writes (index, data); always ready. Write only
//               while no request is in flight.
// Path: an accepted request is written into the queue, then loaded into
//   the output register, where its first frame becomes valid.
// Throughput: one output frame per cycle while frame_out is ready; the
//   repeat counter in the back end replays each request's frame. Inputs
//   run back to back while the four-entry queue has room.
// Reset: rst (synchronous) restores the register defaults (stereo, 16 bit,
//   48000 Hz, 48k sink only) and empties the queue and output register.
// Stall: a held frame_out stays stable; the queue fills, then sample_in
//   ready drops until the receiver takes frames again.
module pcm_stereo16_upsample_converter_core (
  input  logic        clk,
  input  logic        rst,
  pcmup_in_if.sink    sample_in,
  pcmup_out_if.source frame_out,
  pcmup_cfg_if.sink   cfg
);
  import pcmup_pkg::*;

  frame_entry_t push_entry;
  logic         push_valid;
  logic         push_ready;
  frame_entry_t pop_entry;
  logic         pop_valid;
  logic         pop_ready;

  pcmup_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .cfg        (cfg),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  pcmup_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  pcmup_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .frame_out (frame_out)
  );

endmodule

>>> sv/pcmup_checker.sv
// Port-level checks for the PCM repeat upsampler, bound to the top level.
// Depends on pcm_stereo16_upsample_converter_core.
module pcmup_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input pcmup_pkg::sample_t left_out,
  input pcmup_pkg::sample_t right_out,
  input logic               out_rate_sel,
  input logic               format_error,
  input logic               last_of_run
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("frame_out valid right after reset");

  a_error_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && format_error) |->
      (left_out == '0 && right_out == '0 && !out_rate_sel && last_of_run))
    else $error("error frame not cleared or not last");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("repeat run broken off");

  a_run_repeats: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=>
      (left_out == $past(left_out) && right_out == $past(right_out) &&
       out_rate_sel == $past(out_rate_sel)))
    else $error("repeated frame differs");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(left_out) && $stable(right_out) && $stable(last_of_run)))
    else $error("stalled frame changed");

endmodule

bind pcm_stereo16_upsample_converter_core pcmup_checker u_pcmup_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (frame_out.valid),
  .out_ready    (frame_out.ready),
  .left_out     (frame_out.left_out),
  .right_out    (frame_out.right_out),
  .out_rate_sel (frame_out.out_rate_sel),
  .format_error (frame_out.format_error),
  .last_of_run  (frame_out.last_of_run)
);
